/* rtl/c3hl_pkg.sv */
// ----------------------------------------------------------------------------
// c3hl_pkg
// Shared types and constants of the 3x3 horizontal-line convolution block.
// ----------------------------------------------------------------------------
package c3hl_pkg;

  // default geometry and pixel depth
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 8;

  // fixed port field widths
  localparam int IN_PIXEL_BITS = 8;
  localparam int VALUE_BITS    = 8;

  // configuration port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 16;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd1024;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_PADDED_WIDTH  = 1'b0,
    REG_PADDED_HEIGHT = 1'b1
  } c3hl_reg_t;

  // per-pixel flags that travel with a window column
  typedef struct packed {
    logic emit;
    logic row_last;
    logic frame_last;
  } c3hl_tag_t;

endpackage

/* rtl/c3hl_ifs.sv */
// ----------------------------------------------------------------------------
// c3hl_ifs
// Valid/ready stream interfaces: pixel requests in, convolution results out.
// ----------------------------------------------------------------------------
interface c3hl_pix_if
  import c3hl_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [IN_PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface c3hl_res_if
  import c3hl_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         row_last;
  logic                         frame_last;

  modport source (output valid, output value, output row_last, output frame_last,
                  input ready);
  modport sink (input valid, input value, input row_last, input frame_last,
                output ready);
endinterface

/* rtl/c3hl_ram.sv */
// ----------------------------------------------------------------------------
// c3hl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module c3hl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/c3hl_cfg.sv */
// ----------------------------------------------------------------------------
// c3hl_cfg
// APB register file for the frame geometry and the clamped row/column limits.
// ----------------------------------------------------------------------------
module c3hl_cfg
  import c3hl_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_BITS-1:0]     paddr,
  input  logic [APB_DATA_BITS-1:0]     pwdata,
  output logic [APB_DATA_BITS-1:0]     prdata,
  output logic                         pready,
  output logic [$clog2(MAX_WIDTH)-1:0] w_last,
  output logic [HEIGHT_BITS-1:0]       h_last,
  output logic                         restart
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);

  logic [WIDTH_BITS-1:0]  padded_width;
  logic [HEIGHT_BITS-1:0] padded_height;
  c3hl_reg_t              reg_idx;
  logic                   wr_en;

  assign pready  = 1'b1;
  assign reg_idx = c3hl_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  // any register write restarts the frame counters
  assign restart = wr_en;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      padded_width  <= WIDTH_RESET;
      padded_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PADDED_WIDTH:  padded_width  <= pwdata[WIDTH_BITS-1:0];
        REG_PADDED_HEIGHT: padded_height <= pwdata[HEIGHT_BITS-1:0];
        default:           padded_width  <= padded_width;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_PADDED_WIDTH:  prdata = APB_DATA_BITS'(padded_width);
      REG_PADDED_HEIGHT: prdata = APB_DATA_BITS'(padded_height);
      default:           prdata = '0;
    endcase
  end

  // last column index, width clamped to 3..MAX_WIDTH
  always_comb begin
    if (padded_width < WIDTH_BITS'(3)) begin
      w_last = COL_BITS'(2);
    end else if (32'(padded_width) > 32'(MAX_WIDTH)) begin
      w_last = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_BITS'(padded_width - WIDTH_BITS'(1));
    end
  end

  // last row index, height at least 3
  always_comb begin
    if (padded_height < HEIGHT_BITS'(3)) begin
      h_last = HEIGHT_BITS'(2);
    end else begin
      h_last = padded_height - HEIGHT_BITS'(1);
    end
  end

endmodule

/* rtl/c3hl_line_buf.sv */
// ----------------------------------------------------------------------------
// c3hl_line_buf
// Raster counters, two line stores and the column stage that presents
// one new window column (upper, middle, current pixel) per accepted pixel.
// ----------------------------------------------------------------------------
module c3hl_line_buf
  import c3hl_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  c3hl_pix_if.sink                     pix,
  input  logic [$clog2(MAX_WIDTH)-1:0] w_last,
  input  logic [HEIGHT_BITS-1:0]       h_last,
  input  logic                         restart,
  output logic                         col_valid,
  input  logic                         col_take,
  output c3hl_tag_t                    col_tag,
  output logic [PIXEL_BITS-1:0]        col_top,
  output logic [PIXEL_BITS-1:0]        col_mid,
  output logic [PIXEL_BITS-1:0]        col_bot
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);

  logic [COL_BITS-1:0]                  col;
  logic [HEIGHT_BITS-1:0]               row;
  logic                                 accept;
  logic [PIXEL_BITS+IN_PIXEL_BITS-1:0]  pix_ext;
  logic [PIXEL_BITS-1:0]                pix_in;
  logic                                 s1_valid;
  logic [COL_BITS-1:0]                  s1_col;
  logic [PIXEL_BITS-1:0]                s1_pix;
  c3hl_tag_t                            s1_tag;

  // input handshake: column stage empty or moving on
  assign pix.ready = !s1_valid || col_take;
  assign accept    = pix.valid && pix.ready;

  // keep the low PIXEL_BITS bits of the request
  assign pix_ext = {{PIXEL_BITS{1'b0}}, pix.pixel};
  assign pix_in  = pix_ext[PIXEL_BITS-1:0];

  // raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == w_last) begin
        col <= '0;
        row <= (row == h_last) ? '0 : row + HEIGHT_BITS'(1);
      end else begin
        col <= col + COL_BITS'(1);
      end
    end
  end

  // column stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (col_take) begin
      s1_valid <= 1'b0;
    end
  end

  // column stage payload, aligned with the registered line store reads
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col              <= col;
      s1_pix              <= pix_in;
      s1_tag.emit         <= (row >= HEIGHT_BITS'(2)) && (col >= COL_BITS'(2));
      s1_tag.row_last     <= (col == w_last);
      s1_tag.frame_last   <= (col == w_last) && (row == h_last);
    end
  end

  // line stores: upper takes the old middle, middle takes the new pixel
  c3hl_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (col_take),
    .waddr (s1_col),
    .wdata (col_mid),
    .re    (accept),
    .raddr (col),
    .rdata (col_top)
  );

  c3hl_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk   (clk),
    .we    (col_take),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (accept),
    .raddr (col),
    .rdata (col_mid)
  );

  assign col_valid = s1_valid;
  assign col_tag   = s1_tag;
  assign col_bot   = s1_pix;

  // a line store write never lands on the address read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (col_take && accept) |-> (col != s1_col))
    else $error("line store read and write at the same column");

  // column counter wraps after the last column
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && !restart && col == w_last) |=> (col == '0))
    else $error("column counter did not wrap");

  // a stalled column keeps its position
  a_col_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !col_take) |=> (s1_valid && $stable(s1_col)))
    else $error("stalled column stage lost its entry");

endmodule

/* rtl/c3hl_kernel.sv */
// ----------------------------------------------------------------------------
// c3hl_kernel
// 3x3 window, horizontal-line kernel, divide by 16 with rounding half away
// from zero, and the result register.
// ----------------------------------------------------------------------------
module c3hl_kernel
  import c3hl_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  col_valid,
  output logic                  col_take,
  input  c3hl_tag_t             col_tag,
  input  logic [PIXEL_BITS-1:0] col_top,
  input  logic [PIXEL_BITS-1:0] col_mid,
  input  logic [PIXEL_BITS-1:0] col_bot,
  c3hl_res_if.source            res
);

  localparam int SUM_BITS = PIXEL_BITS + 8;

  // window[row][col], row 0 oldest line, col 2 newest column
  logic [PIXEL_BITS-1:0]      win [3][3];
  logic signed [SUM_BITS-1:0] sum;
  logic                       neg;
  logic [SUM_BITS-1:0]        mag;
  logic [SUM_BITS-1:0]        rnd;
  logic [SUM_BITS-1:0]        quo;
  logic                       out_valid;
  logic [VALUE_BITS-1:0]      out_value;
  logic                       out_row_last;
  logic                       out_frame_last;

  // -a + 2b - c over one column
  function automatic logic signed [SUM_BITS-1:0] col_sum(
    input logic [PIXEL_BITS-1:0] a,
    input logic [PIXEL_BITS-1:0] b,
    input logic [PIXEL_BITS-1:0] c
  );
    logic signed [SUM_BITS-1:0] ea;
    logic signed [SUM_BITS-1:0] eb;
    logic signed [SUM_BITS-1:0] ec;
    ea = $signed(SUM_BITS'(a));
    eb = $signed(SUM_BITS'(b));
    ec = $signed(SUM_BITS'(c));
    return (eb <<< 1) - ea - ec;
  endfunction

  // column moves on unless it emits while a result is waiting and not taken
  assign col_take = col_valid && (!col_tag.emit || !out_valid || res.ready);

  // window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win[k][j] <= '0;
        end
      end
    end else if (col_take) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= col_top;
      win[1][2] <= col_mid;
      win[2][2] <= col_bot;
    end
  end

  // kernel sum over the shifted window
  assign sum = col_sum(win[0][1], win[1][1], win[2][1])
             + col_sum(win[0][2], win[1][2], win[2][2])
             + col_sum(col_top, col_mid, col_bot);

  // divide by 16, round half away from zero
  assign neg = sum[SUM_BITS-1];
  assign mag = neg ? SUM_BITS'(-sum) : SUM_BITS'(sum);
  assign rnd = (mag + SUM_BITS'(8)) >> 4;
  assign quo = neg ? -rnd : rnd;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (col_take && col_tag.emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (col_take && col_tag.emit) begin
      out_value      <= quo[VALUE_BITS-1:0];
      out_row_last   <= col_tag.row_last;
      out_frame_last <= col_tag.frame_last;
    end
  end

  assign res.valid      = out_valid;
  assign res.value      = $signed(out_value);
  assign res.row_last   = out_row_last;
  assign res.frame_last = out_frame_last;

  // an emitting column always shows up as a result
  a_emit_out: assert property (@(posedge clk) disable iff (rst)
    (col_take && col_tag.emit) |=> res.valid)
    else $error("emitted window produced no result");

  // end of frame is also end of row
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!res.frame_last || res.row_last))
    else $error("frame_last without row_last");

endmodule

/* rtl/conv3x3_horizontal_line.sv */
// ----------------------------------------------------------------------------
// conv3x3_horizontal_line
// Streaming 3x3 horizontal-line detector on a padded image channel.
//
//   channel  dir  handshake        payload
//   pix      in   valid/ready      pixel[7:0]
//   res      out  valid/ready      value[7:0] signed, row_last, frame_last
//   apb      in   psel/penable     padded_width @0x0, padded_height @0x4
//
// One pixel per clock sustained while the result output is not stalled; an
// accepted pixel is registered in the line store read with the column stage,
// then its window sum is registered in the result reg. Each line store has one
// read and one write port, used once per pixel.
// Synchronous reset clears counters, window and valid flags; line stores are
// not cleared. A stalled result holds the column stage, which then holds the
// pixel input; a waiting result blocks nothing until a column that emits
// reaches the column stage.
// ----------------------------------------------------------------------------
module conv3x3_horizontal_line
  import c3hl_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  c3hl_pix_if.sink                 pix,
  c3hl_res_if.source               res,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);

  logic [COL_BITS-1:0]    w_last;
  logic [HEIGHT_BITS-1:0] h_last;
  logic                   restart;
  logic                   col_valid;
  logic                   col_take;
  c3hl_tag_t              col_tag;
  logic [PIXEL_BITS-1:0]  col_top;
  logic [PIXEL_BITS-1:0]  col_mid;
  logic [PIXEL_BITS-1:0]  col_bot;

  // geometry registers
  c3hl_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .w_last  (w_last),
    .h_last  (h_last),
    .restart (restart)
  );

  // counters and line stores
  c3hl_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .w_last    (w_last),
    .h_last    (h_last),
    .restart   (restart),
    .col_valid (col_valid),
    .col_take  (col_take),
    .col_tag   (col_tag),
    .col_top   (col_top),
    .col_mid   (col_mid),
    .col_bot   (col_bot)
  );

  // window, kernel and result register
  c3hl_kernel #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_kernel (
    .clk       (clk),
    .rst       (rst),
    .col_valid (col_valid),
    .col_take  (col_take),
    .col_tag   (col_tag),
    .col_top   (col_top),
    .col_mid   (col_mid),
    .col_bot   (col_bot),
    .res       (res)
  );

endmodule
